// ===== hdl/tvbe_pkg.sv =====
package tvbe_pkg;

  // Longest encoding: enum header, four tag bytes, integer header, eight value bytes.
  localparam int unsigned MAX_BYTES = 14;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned VEC_W     = 8 * MAX_BYTES;

  typedef enum logic [3:0] {
    OP_BOOL   = 4'd0,
    OP_CHAR   = 4'd1,
    OP_UINT   = 4'd2,
    OP_SINT   = 4'd3,
    OP_F32    = 4'd4,
    OP_F64    = 4'd5,
    OP_PTR    = 4'd6,
    OP_STRREF = 4'd7,
    OP_STRLEN = 4'd8,
    OP_TUPLE  = 4'd9,
    OP_END    = 4'd10,
    OP_STRUCT = 4'd11,
    OP_ENUM   = 4'd12
  } opcode_t;

  localparam logic [7:0] HDR_TRUE      = 8'hE0;
  localparam logic [7:0] HDR_FALSE     = 8'hE1;
  localparam logic [7:0] HDR_NULL_PTR  = 8'hE2;
  localparam logic [7:0] HDR_F32       = 8'hE8;
  localparam logic [7:0] HDR_F64       = 8'hE9;
  localparam logic [7:0] HDR_CHAR      = 8'h41;
  localparam logic [7:0] HDR_UINT      = 8'h00;
  localparam logic [7:0] HDR_NINT      = 8'h20;
  localparam logic [7:0] HDR_STR       = 8'h40;
  localparam logic [7:0] HDR_STR_LEN8  = 8'h5E;
  localparam logic [7:0] HDR_STR_LEN16 = 8'h5F;
  localparam logic [7:0] HDR_STRUCT    = 8'h60;
  localparam logic [7:0] HDR_ENUM      = 8'h64;
  localparam logic [7:0] HDR_TUPLE     = 8'h70;
  localparam logic [7:0] HDR_END       = 8'hFF;
  localparam logic [7:0] HDR_PTR       = 8'hF0;
  localparam logic [7:0] HDR_STRREF    = 8'hF4;
  localparam logic [7:0] INT_IMM_LIMIT = 8'd24;
  localparam logic [7:0] INT_LEN_BASE  = 8'd23;
  localparam logic [15:0] STR_IMM_LIMIT = 16'd30;
  localparam logic [15:0] STR_LEN8_LIMIT = 16'd256;

  // header byte followed by up to eight value bytes, LSB first
  typedef struct packed {
    logic [71:0]      bytes;
    logic [CNT_W-1:0] cnt;
  } int_enc_t;

  // number of significant bytes in v (0 for zero)
  function automatic logic [CNT_W-1:0] byte_len(logic [63:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[8*i +: 8] != 8'd0) n = CNT_W'(i + 1);
    end
    return n;
  endfunction

  function automatic int_enc_t enc_unsigned(logic [63:0] u, logic [7:0] hdr);
    int_enc_t         r;
    logic [CNT_W-1:0] n;
    n = byte_len(u);
    if (u < 64'(INT_IMM_LIMIT)) begin
      r.bytes = {u, hdr + u[7:0]};
      r.cnt   = CNT_W'(1);
    end else begin
      r.bytes = {u, hdr + INT_LEN_BASE + {4'b0, n}};
      r.cnt   = n + CNT_W'(1);
    end
    return r;
  endfunction

  // negative values go out as the complement under the negative header
  function automatic int_enc_t enc_signed(logic [63:0] v);
    if (v[63]) return enc_unsigned(~v, HDR_NINT);
    return enc_unsigned(v, HDR_UINT);
  endfunction

endpackage

// ===== hdl/typed_value_byte_encoder_top.sv =====
// Typed value byte encoder. Each accepted request carries one typed log
// value (opcode selects bool, char, integers, floats, pointer, string
// reference, string length, tuple/end/struct markers or enum) and turns into
// 0 to 14 bytes on the output channel, one byte per transfer, with last set
// on the final byte. A request whose record_logged bit is clear, or whose
// opcode is unused, produces no bytes at all. A request is registered on
// acceptance and fully encoded into a byte buffer once that buffer is free,
// from which the bytes are sent in order. The first byte is presented from
// that buffer, after the input register and the buffer register. The output
// moves one byte per cycle while out_stall is low, and requests producing
// nothing or one byte can be taken every cycle while out_stall is low. The
// next request is accepted while the current one drains, so back-to-back
// byte bursts follow with no gap; each request that produces nothing leaves
// a gap in the output.
// string_space_base is written through the cfg port (always ready) and
// should be changed only while no request is in flight. PTR_BYTES (4..8)
// sets the pointer width used for pointer and string reference encodings.
module typed_value_byte_encoder_top #(
  parameter int unsigned PTR_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [63:0] value,
  input  logic [31:0] type_tag,
  input  logic [15:0] text_length,
  input  logic        record_logged,
  // byte stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  localparam logic [63:0] PTR_MASK = (PTR_BYTES >= 8) ? {64{1'b1}}
                                   : ((64'd1 << (8 * PTR_BYTES)) - 64'd1);
  localparam logic [7:0] ADDR_LONG_OFS = (PTR_BYTES == 4) ? 8'd1 : 8'd2;
  localparam logic [tvbe_pkg::CNT_W-1:0] ADDR_LONG_CNT =
    tvbe_pkg::CNT_W'(PTR_BYTES + 1);
  localparam logic [tvbe_pkg::CNT_W-1:0] ADDR_SHORT_CNT = tvbe_pkg::CNT_W'(4);

  // configuration register
  logic [63:0] string_space_base;

  // input register
  logic        a_valid;
  logic [3:0]  a_opcode;
  logic [63:0] a_value;
  logic [31:0] a_tag;
  logic [15:0] a_len;
  logic        a_logged;

  // encoded byte buffer
  logic                          b_valid;
  logic [tvbe_pkg::VEC_W-1:0]    b_vec;
  logic [tvbe_pkg::CNT_W-1:0]    b_cnt;
  logic [tvbe_pkg::CNT_W-1:0]    idx;

  // encoder outputs
  logic [tvbe_pkg::VEC_W-1:0]    enc_vec;
  logic [tvbe_pkg::CNT_W-1:0]    enc_cnt;

  logic out_xfer, b_done, b_free, a_move, in_accept;

  assign cfg_ready = 1'b1;

  assign out_valid = b_valid;
  assign out_byte  = b_vec[{idx, 3'b000} +: 8];
  assign last      = (idx == b_cnt - tvbe_pkg::CNT_W'(1));

  assign out_xfer  = b_valid && !out_stall;
  assign b_done    = out_xfer && last;
  assign b_free    = !b_valid || b_done;
  assign a_move    = a_valid && b_free;
  assign in_stall  = a_valid && !b_free;
  assign in_accept = in_valid && !in_stall;

  // ---- encoder --------------------------------------------------------------
  logic [63:0]            ptr_val, addr, str_ofs;
  logic [7:0]             addr_hdr;
  logic [tvbe_pkg::VEC_W-1:0] addr_vec;
  logic [tvbe_pkg::CNT_W-1:0] addr_cnt;
  tvbe_pkg::int_enc_t     uenc, senc;
  logic [2:0]             tag_n;      // significant tag bytes, 1..4
  logic [31:0]            tag_masked;
  logic [7:0]             tag_ofs;
  logic [6:0]             enum_shift;

  assign ptr_val = a_value & PTR_MASK;
  assign str_ofs = (ptr_val - string_space_base) & PTR_MASK;
  assign addr    = (a_opcode == tvbe_pkg::OP_STRREF) ? str_ofs : ptr_val;

  always_comb begin
    addr_hdr = (a_opcode == tvbe_pkg::OP_STRREF) ? tvbe_pkg::HDR_STRREF
                                                 : tvbe_pkg::HDR_PTR;
    if (addr < 64'h100_0000) begin
      addr_vec = {40'b0, addr, addr_hdr};
      addr_cnt = ADDR_SHORT_CNT;
    end else begin
      addr_vec = {40'b0, addr, addr_hdr + ADDR_LONG_OFS};
      addr_cnt = ADDR_LONG_CNT;
    end
  end

  assign uenc = tvbe_pkg::enc_unsigned(a_value, tvbe_pkg::HDR_UINT);
  assign senc = tvbe_pkg::enc_signed(a_value);

  always_comb begin
    if (a_tag[31:24] != 8'd0) begin
      tag_n = 3'd4;
      tag_masked = a_tag;
    end else if (a_tag[23:16] != 8'd0) begin
      tag_n = 3'd3;
      tag_masked = {8'b0, a_tag[23:0]};
    end else if (a_tag[15:8] != 8'd0) begin
      tag_n = 3'd2;
      tag_masked = {16'b0, a_tag[15:0]};
    end else begin
      tag_n = 3'd1;
      tag_masked = {24'b0, a_tag[7:0]};
    end
    tag_ofs    = {5'b0, tag_n} - 8'd1;
    enum_shift = {1'b0, tag_n, 3'b000} + 7'd8;
  end

  always_comb begin
    enc_vec = '0;
    enc_cnt = '0;
    case (tvbe_pkg::opcode_t'(a_opcode))
      tvbe_pkg::OP_BOOL: begin
        enc_vec[7:0] = (a_value != 64'd0) ? tvbe_pkg::HDR_TRUE : tvbe_pkg::HDR_FALSE;
        enc_cnt = tvbe_pkg::CNT_W'(1);
      end
      tvbe_pkg::OP_CHAR: begin
        enc_vec[15:0] = {a_value[7:0], tvbe_pkg::HDR_CHAR};
        enc_cnt = tvbe_pkg::CNT_W'(2);
      end
      tvbe_pkg::OP_UINT: begin
        enc_vec = {40'b0, uenc.bytes};
        enc_cnt = uenc.cnt;
      end
      tvbe_pkg::OP_SINT: begin
        enc_vec = {40'b0, senc.bytes};
        enc_cnt = senc.cnt;
      end
      tvbe_pkg::OP_F32: begin
        enc_vec[39:0] = {a_value[31:0], tvbe_pkg::HDR_F32};
        enc_cnt = tvbe_pkg::CNT_W'(5);
      end
      tvbe_pkg::OP_F64: begin
        enc_vec[71:0] = {a_value, tvbe_pkg::HDR_F64};
        enc_cnt = tvbe_pkg::CNT_W'(9);
      end
      tvbe_pkg::OP_PTR: begin
        if (ptr_val == 64'd0) begin
          enc_vec[7:0] = tvbe_pkg::HDR_NULL_PTR;
          enc_cnt = tvbe_pkg::CNT_W'(1);
        end else begin
          enc_vec = addr_vec;
          enc_cnt = addr_cnt;
        end
      end
      tvbe_pkg::OP_STRREF: begin
        if (ptr_val == 64'd0) begin
          enc_vec[7:0] = tvbe_pkg::HDR_STR;
          enc_cnt = tvbe_pkg::CNT_W'(1);
        end else begin
          enc_vec = addr_vec;
          enc_cnt = addr_cnt;
        end
      end
      tvbe_pkg::OP_STRLEN: begin
        if (a_len < tvbe_pkg::STR_IMM_LIMIT) begin
          enc_vec[7:0] = tvbe_pkg::HDR_STR + a_len[7:0];
          enc_cnt = tvbe_pkg::CNT_W'(1);
        end else if (a_len < tvbe_pkg::STR_LEN8_LIMIT) begin
          enc_vec[15:0] = {a_len[7:0], tvbe_pkg::HDR_STR_LEN8};
          enc_cnt = tvbe_pkg::CNT_W'(2);
        end else begin
          enc_vec[23:0] = {a_len, tvbe_pkg::HDR_STR_LEN16};
          enc_cnt = tvbe_pkg::CNT_W'(3);
        end
      end
      tvbe_pkg::OP_TUPLE: begin
        enc_vec[7:0] = tvbe_pkg::HDR_TUPLE;
        enc_cnt = tvbe_pkg::CNT_W'(1);
      end
      tvbe_pkg::OP_END: begin
        enc_vec[7:0] = tvbe_pkg::HDR_END;
        enc_cnt = tvbe_pkg::CNT_W'(1);
      end
      tvbe_pkg::OP_STRUCT: begin
        enc_vec[39:0] = {tag_masked, tvbe_pkg::HDR_STRUCT + tag_ofs};
        enc_cnt = {1'b0, tag_n} + tvbe_pkg::CNT_W'(1);
      end
      tvbe_pkg::OP_ENUM: begin
        // tag header and tag bytes, then the signed value right behind them
        enc_vec = ({40'b0, senc.bytes} << enum_shift)
                | {72'b0, tag_masked, tvbe_pkg::HDR_ENUM + tag_ofs};
        enc_cnt = {1'b0, tag_n} + tvbe_pkg::CNT_W'(1) + senc.cnt;
      end
      default: begin
        enc_vec = '0;
        enc_cnt = '0;
      end
    endcase
    if (!a_logged) enc_cnt = '0;
  end

  // ---- control --------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      string_space_base <= 64'd0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) string_space_base <= cfg_data;
      if (in_accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        // items producing no bytes are simply dropped here
        b_valid <= (enc_cnt != '0);
        idx     <= '0;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end else if (out_xfer) begin
        idx <= idx + tvbe_pkg::CNT_W'(1);
      end
    end
  end

  // ---- payload --------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_opcode <= opcode;
      a_value  <= value;
      a_tag    <= type_tag;
      a_len    <= text_length;
      a_logged <= record_logged;
    end
    if (a_move) begin
      b_vec <= enc_vec;
      b_cnt <= enc_cnt;
    end
  end

  // ---- assertions -----------------------------------------------------------
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < b_cnt))
    else $error("byte index past encoded length");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && b_valid))
    else $error("input stalled with no work pending");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && idx == $past(idx) + 4'd1))
    else $error("byte burst broken before last");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(idx)))
    else $error("byte index moved while stalled");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for the typed value byte encoder.
// Requests are driven one at a time through a shared send task. On each
// accepted request an in-house encoder predicts the byte stream for it and
// queues those bytes. A checker process pops one entry per accepted output
// byte and compares data and last. Directed tests cover the field extremes,
// every opcode and the suppressed cases. Random traffic then runs in four
// phases of idling and stalling, with the string base rewritten before each.
module testbench;

  localparam int unsigned PTR_BYTES = 8;
  localparam logic [63:0] PTR_MASK =
    (PTR_BYTES >= 8) ? '1 : ((64'd1 << (8 * PTR_BYTES)) - 64'd1);
  localparam int OPCODE_LAST    = 2 ** $bits(tvbe_pkg::opcode_t) - 1;
  localparam int RESET_CYCLES   = 12;
  // A request that yields nothing can still be in the pipe when the last
  // queued byte has arrived.
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // Stream header bytes
  localparam logic [7:0] BYTE_TRUE       = 8'hE0;
  localparam logic [7:0] BYTE_FALSE      = 8'hE1;
  localparam logic [7:0] BYTE_NULL_PTR   = 8'hE2;
  localparam logic [7:0] BYTE_F32        = 8'hE8;
  localparam logic [7:0] BYTE_F64        = 8'hE9;
  localparam logic [7:0] BYTE_CHAR       = 8'h41;
  localparam logic [7:0] BASE_UINT       = 8'h00;
  localparam logic [7:0] BASE_NINT       = 8'h20;
  localparam logic [7:0] BASE_TEXT       = 8'h40;
  localparam logic [7:0] BYTE_LEN8       = 8'h5E;
  localparam logic [7:0] BYTE_LEN16      = 8'h5F;
  localparam logic [7:0] BASE_STRUCT     = 8'h60;
  localparam logic [7:0] BASE_ENUM       = 8'h64;
  localparam logic [7:0] BYTE_TUPLE      = 8'h70;
  localparam logic [7:0] BYTE_END        = 8'hFF;
  localparam logic [7:0] BASE_PTR        = 8'hF0;
  localparam logic [7:0] BASE_STRREF     = 8'hF4;
  localparam logic [63:0] IMM_LIMIT      = 64'd24;
  localparam logic [7:0] LEN_BASE        = 8'd23;
  localparam logic [15:0] TEXT_IMM_LIMIT = 16'd30;
  localparam logic [15:0] TEXT_LEN8_LIMIT = 16'd256;
  localparam logic [63:0] SHORT_ADDR_LIMIT = 64'h100_0000;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  opcode = '0;
  logic [63:0] value = '0;
  logic [31:0] type_tag = '0;
  logic [15:0] text_length = '0;
  logic        record_logged = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  // Predictor state: string base register copy and bytes still owed by the DUT
  logic [63:0]  string_base = '0;
  logic [7:0]   item_bytes[$];
  stream_byte_t expected_bytes[$];
  stream_byte_t head;

  int error_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int idle_cycles = 0;

  typed_value_byte_encoder_top #(
    .PTR_BYTES(PTR_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .value        (value),
    .type_tag     (type_tag),
    .text_length  (text_length),
    .record_logged(record_logged),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Byte stream predictor
  // ---------------------------------------------------------------------

  function automatic void emit_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) item_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Immediate header below 24, else 23+n followed by n minimal LE bytes
  function automatic void emit_unsigned(logic [63:0] v, logic [7:0] hdr);
    int          n;
    logic [63:0] rest;
    n    = 0;
    rest = v;
    if (v < IMM_LIMIT) begin
      item_bytes.push_back(hdr + v[7:0]);
    end else begin
      while (rest != '0) begin
        n++;
        rest = rest >> 8;
      end
      item_bytes.push_back(hdr + LEN_BASE + 8'(n));
      emit_le(v, n);
    end
  endfunction

  function automatic void emit_signed(logic [63:0] v);
    if (v[63]) emit_unsigned(~v, BASE_NINT);
    else emit_unsigned(v, BASE_UINT);
  endfunction

  // Tag takes 1..4 bytes; zero still takes one
  function automatic void emit_tag(logic [31:0] tag, logic [7:0] hdr);
    int n;
    if (tag < 32'h100) n = 1;
    else if (tag < 32'h1_0000) n = 2;
    else if (tag < 32'h100_0000) n = 3;
    else n = 4;
    item_bytes.push_back(hdr + 8'(n - 1));
    emit_le(64'(tag), n);
  endfunction

  // Short form below 2^24, otherwise the full pointer width
  function automatic void emit_address(logic [63:0] v, logic [7:0] hdr);
    if (v < SHORT_ADDR_LIMIT) begin
      item_bytes.push_back(hdr);
      emit_le(v, 3);
    end else if (PTR_BYTES == 4) begin
      item_bytes.push_back(hdr + 8'd1);
      emit_le(v, 4);
    end else begin
      item_bytes.push_back(hdr + 8'd2);
      emit_le(v, PTR_BYTES);
    end
  endfunction

  function automatic void encode_item(logic [3:0] op, logic [63:0] val, logic [31:0] tag,
                                      logic [15:0] len, logic logged);
    logic [63:0] addr;
    item_bytes.delete();
    addr = val & PTR_MASK;
    if (logged) begin
      case (op)
        tvbe_pkg::OP_BOOL:
          item_bytes.push_back((val != '0) ? BYTE_TRUE : BYTE_FALSE);
        tvbe_pkg::OP_CHAR: begin
          item_bytes.push_back(BYTE_CHAR);
          item_bytes.push_back(val[7:0]);
        end
        tvbe_pkg::OP_UINT:   emit_unsigned(val, BASE_UINT);
        tvbe_pkg::OP_SINT:   emit_signed(val);
        tvbe_pkg::OP_F32: begin
          item_bytes.push_back(BYTE_F32);
          emit_le(val, 4);
        end
        tvbe_pkg::OP_F64: begin
          item_bytes.push_back(BYTE_F64);
          emit_le(val, 8);
        end
        tvbe_pkg::OP_PTR: begin
          if (addr == '0) item_bytes.push_back(BYTE_NULL_PTR);
          else emit_address(addr, BASE_PTR);
        end
        tvbe_pkg::OP_STRREF: begin
          // null reference is tested before the base is taken off
          if (addr == '0) item_bytes.push_back(BASE_TEXT);
          else emit_address((addr - string_base) & PTR_MASK, BASE_STRREF);
        end
        tvbe_pkg::OP_STRLEN: begin
          if (len < TEXT_IMM_LIMIT) begin
            item_bytes.push_back(BASE_TEXT + len[7:0]);
          end else if (len < TEXT_LEN8_LIMIT) begin
            item_bytes.push_back(BYTE_LEN8);
            item_bytes.push_back(len[7:0]);
          end else begin
            item_bytes.push_back(BYTE_LEN16);
            item_bytes.push_back(len[7:0]);
            item_bytes.push_back(len[15:8]);
          end
        end
        tvbe_pkg::OP_TUPLE:  item_bytes.push_back(BYTE_TUPLE);
        tvbe_pkg::OP_END:    item_bytes.push_back(BYTE_END);
        tvbe_pkg::OP_STRUCT: emit_tag(tag, BASE_STRUCT);
        tvbe_pkg::OP_ENUM: begin
          emit_tag(tag, BASE_ENUM);
          emit_signed(val);
        end
        default: ;  // unused opcodes emit nothing
      endcase
    end
    foreach (item_bytes[i])
      expected_bytes.push_back('{data: item_bytes[i], is_last: (i == item_bytes.size() - 1)});
  endfunction

  // ---------------------------------------------------------------------
  // Checking and receiver side
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Reads happen before the DUT's edge updates land, so values are pre-edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h last %0b with nothing expected", out_byte, last));
      end else begin
        head = expected_bytes.pop_front();
        if (out_byte !== head.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, head.data));
        if (last !== head.is_last)
          report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                    last, out_byte, head.is_last));
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // Ends a hung run: counts consecutive cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // in_valid stays high on return; a caller that pauses calls settle_stream
  task automatic send_request(input logic [3:0] op, input logic [63:0] val,
                              input logic [31:0] tag, input logic [15:0] len,
                              input logic logged);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    value         <= val;
    type_tag      <= tag;
    text_length   <= len;
    record_logged <= logged;
    do @(posedge clk); while (in_stall);
    encode_item(op, val, tag, len, logged);
  endtask

  // Drop valid, wait for every queued byte, then let the pipe empty
  task automatic settle_stream();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle
  task automatic write_string_base(input logic [63:0] base);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    string_base = base;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [3:0]  op;
    logic [63:0] val;
    logic [31:0] tag;
    logic [15:0] len;
    logic        logged;
    if ($urandom_range(0, 99) < 5)
      op = 4'($urandom_range(tvbe_pkg::OP_ENUM + 1, OPCODE_LAST));
    else
      op = 4'($urandom_range(tvbe_pkg::OP_BOOL, tvbe_pkg::OP_ENUM));
    logged = ($urandom_range(0, 99) >= 7);
    // value spread over immediates, every byte length, and both signs
    case ($urandom_range(0, 4))
      0: val = 64'($urandom_range(0, 30));
      1: val = ~64'($urandom_range(0, 30));
      2: begin
        val = {$urandom, $urandom} >> (8 * $urandom_range(0, 7));
        if ($urandom_range(0, 1)) val = ~val;
      end
      default: val = {$urandom, $urandom};
    endcase
    // string addresses near the base give short offsets
    if (op == tvbe_pkg::OP_STRREF && $urandom_range(0, 1))
      val = string_base + 64'($urandom_range(0, 'hFF_FFFF));
    case ($urandom_range(0, 3))
      0: tag = '0;
      1: tag = $urandom_range(1, 255);
      default: tag = $urandom >> (8 * $urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 2))
      0: len = 16'($urandom_range(0, 29));
      1: len = 16'($urandom_range(30, 255));
      default: len = 16'($urandom_range(256, 65535));
    endcase
    send_request(op, val, tag, len, logged);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_scalars();
    send_request(tvbe_pkg::OP_BOOL, '1, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_BOOL, '0, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_CHAR, '1, $urandom, 16'($urandom), 1'b1);
    // upper half must not leak
    send_request(tvbe_pkg::OP_F32, '1, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_F64, 64'h0123_4567_89AB_CDEF, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_TUPLE, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_END, {$urandom, $urandom}, $urandom, 16'($urandom), 1'b1);
  endtask

  task automatic test_integers();
    // last immediate, then first with length
    send_request(tvbe_pkg::OP_UINT, 64'd23, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_UINT, 64'd24, $urandom, 16'($urandom), 1'b1);
    // nine bytes, then minus one
    send_request(tvbe_pkg::OP_UINT, '1, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_SINT, '1, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_SINT, 64'h8000_0000_0000_0000, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_SINT, 64'h7FFF_FFFF_FFFF_FFFF, $urandom, 16'($urandom), 1'b1);
  endtask

  task automatic test_addresses();
    send_request(tvbe_pkg::OP_PTR, '0, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_PTR, 64'hFF_FFFF, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_PTR, SHORT_ADDR_LIMIT, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_PTR, '1, $urandom, 16'($urandom), 1'b1);
    // null reference
    send_request(tvbe_pkg::OP_STRREF, '0, $urandom, 16'($urandom), 1'b1);
  endtask

  task automatic test_strings();
    send_request(tvbe_pkg::OP_STRLEN, {$urandom, $urandom}, $urandom, 16'd29, 1'b1);
    send_request(tvbe_pkg::OP_STRLEN, {$urandom, $urandom}, $urandom, 16'd30, 1'b1);
    send_request(tvbe_pkg::OP_STRLEN, {$urandom, $urandom}, $urandom, 16'hFFFF, 1'b1);
  endtask

  task automatic test_containers();
    send_request(tvbe_pkg::OP_STRUCT, {$urandom, $urandom}, 32'd0, 16'($urandom), 1'b1);
    // longest encoding: four tag bytes plus a nine-byte integer
    send_request(tvbe_pkg::OP_ENUM, 64'h7FFF_FFFF_FFFF_FFFF, '1, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_ENUM, ~64'd24, 32'h100, 16'($urandom), 1'b1);
  endtask

  // Unused opcode and unlogged record: no bytes; a bool after proves nothing leaked
  task automatic test_suppressed();
    send_request(4'(OPCODE_LAST), '1, '1, '1, 1'b1);
    send_request(tvbe_pkg::OP_ENUM, '1, '1, '1, 1'b0);
    send_request(tvbe_pkg::OP_BOOL, 64'd1, $urandom, 16'($urandom), 1'b1);
  endtask

  task automatic test_string_base();
    settle_stream();
    write_string_base('1);
    // wraps to offset 2, then offset zero
    send_request(tvbe_pkg::OP_STRREF, 64'd1, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_STRREF, '1, $urandom, 16'($urandom), 1'b1);
    settle_stream();
    write_string_base({$urandom, $urandom});
    send_request(tvbe_pkg::OP_STRREF, string_base + 64'h10, $urandom, 16'($urandom), 1'b1);
    send_request(tvbe_pkg::OP_STRREF, string_base - 64'd1, $urandom, 16'($urandom), 1'b1);
  endtask

  task automatic test_random_traffic(input int count, input int sender_idle,
                                     input int receiver_stall, input logic [63:0] base);
    settle_stream();
    write_string_base(base);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_random_item();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // string base still at its reset value here
    test_scalars();
    test_integers();
    test_addresses();
    test_strings();
    test_containers();
    test_suppressed();
    test_string_base();

    test_random_traffic(17, 0, 0, '0);
    test_random_traffic(17, 52, 0, {$urandom, $urandom});
    test_random_traffic(17, 0, 52, {$urandom, $urandom});
    test_random_traffic(17, 22, 22, {$urandom, $urandom});

    settle_stream();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
